FILE: sv/g2e_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CORDIC arctangent table function for geodetic_to_ecef.
// Depends on nothing; used by g2e_mulsh and geodetic_to_ecef.
package g2e_pkg;

  // Q62 word used for angles, sine, cosine, e2 and the inverse square root
  typedef logic signed [63:0] q62_t;

  // Stages in one rounded 64x64 multiply
  localparam int unsigned MUL_LAT  = 4;
  // Quotient bits of the degree-to-radian remainder division
  localparam int unsigned DIV_BITS = 30;
  // Newton iterations of the inverse square root
  localparam int unsigned NR_ITERS = 6;

  localparam logic [63:0] PI_Q62       = 64'hC90FDAA22168C235;
  localparam q62_t        PI4_Q62      = 64'sh3243F6A8885A308D;
  localparam q62_t        ONE_Q62      = 64'sh4000000000000000;
  localparam q62_t        K_Q62        = 64'sd2800459870029452954;
  localparam q62_t        E2_Q62       = 64'sd30872378602574782;
  localparam q62_t        ONE_M_E2_Q62 = ONE_Q62 - E2_Q62;
  localparam q62_t        A_MM         = 64'sd6378137000;

  localparam logic [31:0] HALF_TURN    = 32'd1800000000;
  localparam logic [31:0] QUARTER_TURN = 32'd900000000;

  // pi*2^62 split as QC * half turn + RC
  localparam logic [32:0] DIV_QC = 33'(PI_Q62 / 64'(HALF_TURN));
  localparam logic [30:0] DIV_RC = 31'(PI_Q62 % 64'(HALF_TURN));

  // Sideband carried through the angle and CORDIC stages
  typedef struct packed {
    logic              err;
    logic              flip;
    logic signed [26:0] h;
  } front_t;

  // Sideband carried through the radius and projection stages
  typedef struct packed {
    logic              err;
    logic signed [26:0] h;
    q62_t              cl;
    q62_t              sl;
    q62_t              co;
    q62_t              so;
  } side_t;

  // One lane of the restoring division
  typedef struct packed {
    logic [62:0]         prod;
    logic [60:0]         rem;
    logic [DIV_BITS-1:0] q;
    logic                neg;
  } div_t;

  // atan(2^-i) in Q62 from its power series, term by term
  function automatic q62_t atan_pow2(input int unsigned i);
    q62_t        acc;
    logic [63:0] t;
    int unsigned e;
    acc = '0;
    if (i == 0) begin
      acc = PI4_Q62;
    end else begin
      for (int unsigned k = 0; k < 32; k++) begin
        if (i * (2 * k + 1) <= 62) begin
          e = 62 - i * (2 * k + 1);
          t = (64'd1 << e) / 64'(2 * k + 1);
          if (k[0]) begin
            acc = acc - $signed(t);
          end else begin
            acc = acc + $signed(t);
          end
        end
      end
    end
    return acc;
  endfunction

endpackage

FILE: sv/g2e_mulsh.sv
`timescale 1ns / 1ps
// Four-stage signed 64x64 multiply, rounded to nearest (ties away from zero) and shifted by SH.
// Depends on g2e_pkg.
module g2e_mulsh #(
  parameter int unsigned SH = 62
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  g2e_pkg::q62_t a_i,
  input  g2e_pkg::q62_t b_i,
  output g2e_pkg::q62_t p_o
);

  logic [63:0]  ua_q, ub_q;
  logic         neg_a_q, neg_b_q, neg_c_q;
  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic [63:0]  res_q;
  logic [127:0] sum;

  // Add the partial products and the rounding half
  assign sum = {64'd0, p00_q} + {32'd0, p01_q, 32'd0} + {32'd0, p10_q, 32'd0}
             + {p11_q, 64'd0} + (128'd1 << (SH - 1));

  // Take magnitudes, form partial products, round, restore sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua_q    <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      ub_q    <= b_i[63] ? 64'(-b_i) : 64'(b_i);
      neg_a_q <= a_i[63] ^ b_i[63];
      p00_q   <= ua_q[31:0]  * ub_q[31:0];
      p01_q   <= ua_q[31:0]  * ub_q[63:32];
      p10_q   <= ua_q[63:32] * ub_q[31:0];
      p11_q   <= ua_q[63:32] * ub_q[63:32];
      neg_b_q <= neg_a_q;
      res_q   <= sum[SH+63:SH];
      neg_c_q <= neg_b_q;
      p_o     <= neg_c_q ? -$signed(res_q) : $signed(res_q);
    end
  end

endmodule

FILE: sv/geodetic_to_ecef.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle while the output is not stalled.
// Every stage, CORDIC step and multiply is registered.
// A stalled output freezes the whole pipeline; no request is dropped or repeated.
// Reset clears only the valid bits; data registers hold whatever they last took.
// Depends on g2e_pkg and g2e_mulsh.
module geodetic_to_ecef #(
  parameter int unsigned CORDIC_STEPS = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [30:0] latitude_i,
  input  logic signed [31:0] longitude_i,
  input  logic signed [26:0] height_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [33:0] x_mm_o,
  output logic signed [33:0] y_mm_o,
  output logic signed [33:0] z_mm_o,
  output logic               angle_error_o
);

  localparam int unsigned L      = g2e_pkg::MUL_LAT;
  localparam int unsigned DB     = g2e_pkg::DIV_BITS;
  localparam int unsigned NI     = g2e_pkg::NR_ITERS;
  localparam int unsigned FR_N   = 3 + DB + CORDIC_STEPS;
  localparam int unsigned SD_N   = 23 * L;
  localparam int unsigned WD_N   = L + 3 * L * (NI - 1);
  localparam int unsigned PIPE_N = 35 + CORDIC_STEPS + SD_N;
  localparam logic signed [32:0] QT_S = 33'(g2e_pkg::QUARTER_TURN);
  localparam logic signed [32:0] HT_S = 33'(g2e_pkg::HALF_TURN);

  logic en;
  logic [PIPE_N:1] vld_q;

  // Advance unless the result register is full and held
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[PIPE_N];

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_N-1:1], in_valid_i};
    end
  end

  // ---------------- input check and longitude fold ----------------
  logic signed [32:0] lat33, lon33, lonr;
  logic               err, flip;
  logic [DB-1:0]      ua_q [2];
  logic               ng_q [2];
  g2e_pkg::front_t    fr_q [1:FR_N];

  always_comb begin
    lat33 = 33'(latitude_i);
    lon33 = 33'(longitude_i);
    err   = (lat33 > QT_S) || (lat33 < -QT_S) || (lon33 > HT_S) || (lon33 < -HT_S);
    priority if (lon33 > QT_S) begin
      lonr = lon33 - HT_S;
      flip = 1'b1;
    end else if (lon33 < -QT_S) begin
      lonr = lon33 + HT_S;
      flip = 1'b1;
    end else begin
      lonr = lon33;
      flip = 1'b0;
    end
  end

  // Register magnitudes and signs of both angles
  always_ff @(posedge clk_i) begin
    if (en) begin
      ua_q[0]    <= lat33[32] ? DB'(-lat33) : DB'(lat33);
      ng_q[0]    <= lat33[32];
      ua_q[1]    <= lonr[32] ? DB'(-lonr) : DB'(lonr);
      ng_q[1]    <= lonr[32];
      fr_q[1]    <= '{err: err, flip: flip, h: height_i};
    end
  end

  // Carry sideband alongside the angle stages
  for (genvar k = 2; k <= FR_N; k++) begin : g_fr
    always_ff @(posedge clk_i) begin
      if (en) begin
        fr_q[k] <= fr_q[k-1];
      end
    end
  end

  // ---------------- degree units to Q62 radians ----------------
  g2e_pkg::div_t dv_q [DB+1][2];
  g2e_pkg::q62_t cx_q [CORDIC_STEPS+1][2];
  g2e_pkg::q62_t cy_q [CORDIC_STEPS+1][2];
  g2e_pkg::q62_t cz_q [CORDIC_STEPS+1][2];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [63:0] rad;

    // Split u*pi into whole half turns and a remainder to divide
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[0][l].prod <= 63'(ua_q[l]) * 63'(g2e_pkg::DIV_QC);
        dv_q[0][l].rem  <= 61'(ua_q[l]) * 61'(g2e_pkg::DIV_RC)
                         + 61'(g2e_pkg::QUARTER_TURN);
        dv_q[0][l].q    <= '0;
        dv_q[0][l].neg  <= ng_q[l];
      end
    end

    // Restoring division by the half turn, one quotient bit a stage
    for (genvar j = 0; j < DB; j++) begin : g_div
      localparam logic [60:0]   DSH  = 61'(g2e_pkg::HALF_TURN) << (DB - 1 - j);
      localparam logic [DB-1:0] QBIT = DB'(1) << (DB - 1 - j);
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_q[j+1][l].prod <= dv_q[j][l].prod;
          dv_q[j+1][l].neg  <= dv_q[j][l].neg;
          if (dv_q[j][l].rem >= DSH) begin
            dv_q[j+1][l].rem <= dv_q[j][l].rem - DSH;
            dv_q[j+1][l].q   <= dv_q[j][l].q | QBIT;
          end else begin
            dv_q[j+1][l].rem <= dv_q[j][l].rem;
            dv_q[j+1][l].q   <= dv_q[j][l].q;
          end
        end
      end
    end

    assign rad = 64'(dv_q[DB][l].prod) + 64'(dv_q[DB][l].q);

    // Load the CORDIC with the signed angle
    always_ff @(posedge clk_i) begin
      if (en) begin
        cx_q[0][l] <= g2e_pkg::K_Q62;
        cy_q[0][l] <= '0;
        cz_q[0][l] <= dv_q[DB][l].neg ? -$signed(rad) : $signed(rad);
      end
    end

    // CORDIC rotation, one micro-rotation a stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      localparam g2e_pkg::q62_t ATAN_I = g2e_pkg::atan_pow2(i);
      g2e_pkg::q62_t dx, dy;
      assign dx = cy_q[i][l] >>> i;
      assign dy = cx_q[i][l] >>> i;
      always_ff @(posedge clk_i) begin
        if (en) begin
          if (!cz_q[i][l][63]) begin
            cx_q[i+1][l] <= cx_q[i][l] - dx;
            cy_q[i+1][l] <= cy_q[i][l] + dy;
            cz_q[i+1][l] <= cz_q[i][l] - ATAN_I;
          end else begin
            cx_q[i+1][l] <= cx_q[i][l] + dx;
            cy_q[i+1][l] <= cy_q[i][l] - dy;
            cz_q[i+1][l] <= cz_q[i][l] + ATAN_I;
          end
        end
      end
    end
  end

  // ---------------- sideband line for the radius stages ----------------
  g2e_pkg::side_t sd_q [SD_N+1];
  g2e_pkg::front_t fr_end;

  assign fr_end = fr_q[FR_N];

  // Apply the half-turn flip to the longitude terms
  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0].err <= fr_end.err;
      sd_q[0].h   <= fr_end.h;
      sd_q[0].cl  <= cx_q[CORDIC_STEPS][0];
      sd_q[0].sl  <= cy_q[CORDIC_STEPS][0];
      sd_q[0].co  <= fr_end.flip ? -cx_q[CORDIC_STEPS][1] : cx_q[CORDIC_STEPS][1];
      sd_q[0].so  <= fr_end.flip ? -cy_q[CORDIC_STEPS][1] : cy_q[CORDIC_STEPS][1];
    end
  end

  for (genvar k = 1; k <= SD_N; k++) begin : g_sd
    always_ff @(posedge clk_i) begin
      if (en) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // ---------------- w = 1 - e2*sin^2(lat) ----------------
  g2e_pkg::q62_t m_ss, m_ess, w0;

  g2e_mulsh #(.SH(62)) u_ss (
    .clk_i(clk_i), .en_i(en), .a_i(sd_q[0].sl), .b_i(sd_q[0].sl), .p_o(m_ss)
  );
  g2e_mulsh #(.SH(62)) u_ess (
    .clk_i(clk_i), .en_i(en), .a_i(g2e_pkg::E2_Q62), .b_i(m_ss), .p_o(m_ess)
  );

  assign w0 = g2e_pkg::ONE_Q62 - m_ess;

  // Delay w for each Newton iteration
  g2e_pkg::q62_t wd_q [1:WD_N];
  always_ff @(posedge clk_i) begin
    if (en) begin
      wd_q[1] <= w0;
    end
  end
  for (genvar k = 2; k <= WD_N; k++) begin : g_wd
    always_ff @(posedge clk_i) begin
      if (en) begin
        wd_q[k] <= wd_q[k-1];
      end
    end
  end

  // ---------------- Newton inverse square root ----------------
  g2e_pkg::q62_t y_in [NI+1];
  assign y_in[0] = g2e_pkg::ONE_Q62;

  for (genvar n = 0; n < NI; n++) begin : g_nr
    g2e_pkg::q62_t yd_q [1:3*L];
    g2e_pkg::q62_t m_yy, m_wyy, m_yd;

    // Hold y until its correction arrives
    always_ff @(posedge clk_i) begin
      if (en) begin
        yd_q[1] <= y_in[n];
      end
    end
    for (genvar k = 2; k <= 3 * L; k++) begin : g_yd
      always_ff @(posedge clk_i) begin
        if (en) begin
          yd_q[k] <= yd_q[k-1];
        end
      end
    end

    g2e_mulsh #(.SH(62)) u_yy (
      .clk_i(clk_i), .en_i(en), .a_i(y_in[n]), .b_i(y_in[n]), .p_o(m_yy)
    );
    g2e_mulsh #(.SH(62)) u_wyy (
      .clk_i(clk_i), .en_i(en), .a_i(wd_q[L + 3 * L * n]), .b_i(m_yy), .p_o(m_wyy)
    );
    g2e_mulsh #(.SH(63)) u_yd (
      .clk_i(clk_i), .en_i(en), .a_i(yd_q[2 * L]), .b_i(g2e_pkg::ONE_Q62 - m_wyy),
      .p_o(m_yd)
    );

    assign y_in[n+1] = yd_q[3 * L] + m_yd;
  end

  // ---------------- radii and projections ----------------
  g2e_pkg::q62_t m_n, m_t, m_nr, m_x, m_y, m_z, r1, r2, h21, h22;

  assign h21 = {{13{sd_q[21*L].h[26]}}, sd_q[21*L].h, 24'd0};
  assign h22 = {{13{sd_q[22*L].h[26]}}, sd_q[22*L].h, 24'd0};

  g2e_mulsh #(.SH(38)) u_n (
    .clk_i(clk_i), .en_i(en), .a_i(g2e_pkg::A_MM), .b_i(y_in[NI]), .p_o(m_n)
  );

  assign r1 = m_n + h21;

  g2e_mulsh #(.SH(62)) u_t (
    .clk_i(clk_i), .en_i(en), .a_i(r1), .b_i(sd_q[21*L].cl), .p_o(m_t)
  );
  g2e_mulsh #(.SH(62)) u_nr (
    .clk_i(clk_i), .en_i(en), .a_i(m_n), .b_i(g2e_pkg::ONE_M_E2_Q62), .p_o(m_nr)
  );

  assign r2 = m_nr + h22;

  g2e_mulsh #(.SH(62)) u_x (
    .clk_i(clk_i), .en_i(en), .a_i(m_t), .b_i(sd_q[22*L].co), .p_o(m_x)
  );
  g2e_mulsh #(.SH(62)) u_y (
    .clk_i(clk_i), .en_i(en), .a_i(m_t), .b_i(sd_q[22*L].so), .p_o(m_y)
  );
  g2e_mulsh #(.SH(62)) u_z (
    .clk_i(clk_i), .en_i(en), .a_i(r2), .b_i(sd_q[22*L].sl), .p_o(m_z)
  );

  // ---------------- round to millimetres ----------------
  logic [63:0] rx, ry, rz;
  assign rx = m_x + 64'sd8388608;
  assign ry = m_y + 64'sd8388608;
  assign rz = m_z + 64'sd8388608;

  // Drop to zero on an angle error
  always_ff @(posedge clk_i) begin
    if (en) begin
      angle_error_o <= sd_q[SD_N].err;
      x_mm_o        <= sd_q[SD_N].err ? '0 : $signed(rx[57:24]);
      y_mm_o        <= sd_q[SD_N].err ? '0 : $signed(ry[57:24]);
      z_mm_o        <= sd_q[SD_N].err ? '0 : $signed(rz[57:24]);
    end
  end

  // ---------------- assertions ----------------
  localparam int unsigned LV_DIV = 2 + DB;
  localparam int unsigned LV_COR = 33 + CORDIC_STEPS;
  localparam g2e_pkg::q62_t ZLIM = 64'sd1 <<< (63 - CORDIC_STEPS);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && angle_error_o) |-> (x_mm_o == '0 && y_mm_o == '0 && z_mm_o == '0))
    else $error("angle error result carries nonzero coordinates");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LV_DIV] && !fr_q[LV_DIV].err)
      |-> (dv_q[DB][0].rem < 61'(g2e_pkg::HALF_TURN)
           && dv_q[DB][1].rem < 61'(g2e_pkg::HALF_TURN)))
    else $error("radian division left a remainder of a full divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LV_COR] && !fr_q[LV_COR].err)
      |-> (cz_q[CORDIC_STEPS][0] <= ZLIM && cz_q[CORDIC_STEPS][0] >= -ZLIM
           && cz_q[CORDIC_STEPS][1] <= ZLIM && cz_q[CORDIC_STEPS][1] >= -ZLIM))
    else $error("CORDIC residual angle did not converge");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("pipeline advanced over a held result");

endmodule
